FILE: rtl/core/tcw_pkg.sv
package tcw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BLANK   = 8'h00;

  localparam logic [7:0] FILL_RESET = 8'h0F;

  typedef enum logic [3:0] {
    ST_RESET_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_READ_WAIT,
    ST_TAB_MOD,
    ST_PUT,
    ST_SCROLL_COPY,
    ST_SCROLL_DRAIN,
    ST_SCROLL_FILL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_index;
    logic        scrolled;
  } out_item_t;

  typedef struct packed {
    logic char_en;
    logic color_en;
  } cell_we_t;

endpackage

FILE: rtl/core/tcw_cell_ram.sv
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  tcw_pkg::cell_we_t we,
  input  logic [AW-1:0]     waddr,
  input  logic [7:0]        wchar,
  input  logic [7:0]        wcolor,
  input  logic [AW-1:0]     raddr,
  output logic [7:0]        rchar,
  output logic [7:0]        rcolor
);
  import tcw_pkg::*;

  logic [7:0] char_mem [DEPTH];
  logic [7:0] color_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.char_en) begin
      char_mem[waddr] <= wchar;
    end
    if (we.color_en) begin
      color_mem[waddr] <= wcolor;
    end
    rchar  <= char_mem[raddr];
    rcolor <= color_mem[raddr];
  end

endmodule

FILE: rtl/core/text_console_writer_unit.sv
// Character-cell text console: a ROWS x COLUMNS grid of character and color
// bytes plus a cursor, kept in a single-port-write, single-port-read cell ram.
// Input channel (in_valid / in_stall / in_item) takes one command per
// transaction: put character, clear screen or read cell. Each command gives
// exactly one result on the output channel (out_valid / out_stall / out_item)
// carrying the read cell (zero unless reading) and the cursor after the command.
// The config channel (cfg_valid / cfg_ready / cfg_data) sets the fill color
// used by clear and scroll; it is always ready.
// A tab finds its length with a subtract loop (column mod TAB_STOP) before it
// writes its spaces; a newline on the bottom row, or a character or space that
// wraps past the last cell, scrolls the screen up one row. The sequencer works
// on one command at a time and walks the cell ram one cell per cycle, so clear
// and scroll set the worst-case rate.
// After reset the block clears all CELLS cells and holds in_stall high until
// that pass is done.
// A finished result waits in the output register while out_stall is high; the
// next command is already accepted meanwhile, and it completes once the slot
// frees up.
module text_console_writer_unit #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int TW    = $clog2(TAB_STOP + 1);

  localparam logic [AW-1:0] LAST_CELL        = AW'(CELLS - 1);
  localparam logic [AW-1:0] BOTTOM_ROW_START = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP         = AW'(COLUMNS);
  localparam logic [CW-1:0] LAST_COL         = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW         = RW'(ROWS - 1);
  localparam logic [6:0]    TAB_K            = 7'(TAB_STOP);

  state_t          state, state_next;
  logic [AW-1:0]   cnt, cnt_next;
  logic [CW-1:0]   cur_col, cur_col_next;
  logic [RW-1:0]   cur_row, cur_row_next;
  logic [AW-1:0]   cur_addr, cur_addr_next;
  logic [7:0]      put_ch, put_ch_next;
  logic [TW-1:0]   put_left, put_left_next;
  logic [6:0]      tab_rem, tab_rem_next;
  logic            scrolled, scrolled_next;
  logic [7:0]      res_char, res_char_next;
  logic [7:0]      res_color, res_color_next;
  logic [AW-1:0]   rd_addr, rd_addr_next;
  logic            pend, pend_next;
  logic [AW-1:0]   wdst, wdst_next;
  logic [7:0]      fill_color;
  logic            out_load;

  cell_we_t        mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [7:0]      mem_wchar;
  logic [7:0]      mem_wcolor;
  logic [AW-1:0]   mem_raddr;
  logic [7:0]      mem_rchar;
  logic [7:0]      mem_rcolor;

  logic            accept;
  logic            out_free;
  logic            rd_in_range;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign rd_in_range = (int'(in_item.row) < ROWS) && (int'(in_item.col) < COLUMNS);

  tcw_cell_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wchar (mem_wchar),
    .wcolor(mem_wcolor),
    .raddr (mem_raddr),
    .rchar (mem_rchar),
    .rcolor(mem_rcolor)
  );

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    cur_addr_next  = cur_addr;
    put_ch_next    = put_ch;
    put_left_next  = put_left;
    tab_rem_next   = tab_rem;
    scrolled_next  = scrolled;
    res_char_next  = res_char;
    res_color_next = res_color;
    rd_addr_next   = rd_addr;
    pend_next      = 1'b0;
    wdst_next      = wdst;
    out_load       = 1'b0;
    mem_we         = '0;
    mem_waddr      = cnt;
    mem_wchar      = CH_BLANK;
    mem_wcolor     = fill_color;
    mem_raddr      = rd_addr;

    unique case (state)
      ST_RESET_CLEAR: begin
        mem_we     = '{char_en: 1'b1, color_en: 1'b1};
        mem_wcolor = FILL_RESET;
        cnt_next   = cnt + AW'(1);
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          scrolled_next  = 1'b0;
          res_char_next  = '0;
          res_color_next = '0;
          state_next     = ST_DONE;
          case (in_item.op)
            OP_PUT: begin
              case (in_item.char_code)
                CH_NEWLINE: begin
                  cur_col_next  = '0;
                  put_left_next = '0;
                  if (cur_row == LAST_ROW) begin
                    cur_addr_next = BOTTOM_ROW_START;
                    scrolled_next = 1'b1;
                    cnt_next      = ROW_STEP;
                    state_next    = ST_SCROLL_COPY;
                  end else begin
                    cur_row_next  = cur_row + RW'(1);
                    cur_addr_next = cur_addr - AW'(cur_col) + ROW_STEP;
                  end
                end
                CH_RETURN: begin
                  cur_col_next  = '0;
                  cur_addr_next = cur_addr - AW'(cur_col);
                end
                CH_TAB: begin
                  tab_rem_next = 7'(cur_col);
                  put_ch_next  = CH_SPACE;
                  state_next   = ST_TAB_MOD;
                end
                default: begin
                  put_ch_next   = in_item.char_code;
                  put_left_next = TW'(1);
                  state_next    = ST_PUT;
                end
              endcase
            end
            OP_CLEAR: begin
              cnt_next      = '0;
              cur_col_next  = '0;
              cur_row_next  = '0;
              cur_addr_next = '0;
              state_next    = ST_CLEAR;
            end
            OP_READ: begin
              if (rd_in_range) begin
                rd_addr_next = AW'(in_item.row) * ROW_STEP + AW'(in_item.col);
                state_next   = ST_READ;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_READ: begin
        state_next = ST_READ_WAIT;
      end

      ST_READ_WAIT: begin
        res_char_next  = mem_rchar;
        res_color_next = mem_rcolor;
        state_next     = ST_DONE;
      end

      // column mod tab stop by repeated subtraction
      ST_TAB_MOD: begin
        if (tab_rem >= TAB_K) begin
          tab_rem_next = tab_rem - TAB_K;
        end else begin
          put_left_next = TW'(TAB_K - tab_rem);
          state_next    = ST_PUT;
        end
      end

      ST_PUT: begin
        mem_we.char_en = 1'b1;
        mem_waddr      = cur_addr;
        mem_wchar      = put_ch;
        put_left_next  = put_left - TW'(1);
        if (put_left == TW'(1)) begin
          state_next = ST_DONE;
        end
        if (cur_col == LAST_COL) begin
          cur_col_next = '0;
          if (cur_row == LAST_ROW) begin
            cur_addr_next = BOTTOM_ROW_START;
            scrolled_next = 1'b1;
            cnt_next      = ROW_STEP;
            state_next    = ST_SCROLL_COPY;
          end else begin
            cur_row_next  = cur_row + RW'(1);
            cur_addr_next = cur_addr + AW'(1);
          end
        end else begin
          cur_col_next  = cur_col + CW'(1);
          cur_addr_next = cur_addr + AW'(1);
        end
      end

      // read one cell per cycle, write it one row up on the next
      ST_SCROLL_COPY: begin
        mem_raddr = cnt;
        if (pend) begin
          mem_we     = '{char_en: 1'b1, color_en: 1'b1};
          mem_waddr  = wdst;
          mem_wchar  = mem_rchar;
          mem_wcolor = mem_rcolor;
        end
        pend_next = 1'b1;
        wdst_next = cnt - ROW_STEP;
        cnt_next  = cnt + AW'(1);
        if (cnt == LAST_CELL) begin
          state_next = ST_SCROLL_DRAIN;
        end
      end

      ST_SCROLL_DRAIN: begin
        if (pend) begin
          mem_we     = '{char_en: 1'b1, color_en: 1'b1};
          mem_waddr  = wdst;
          mem_wchar  = mem_rchar;
          mem_wcolor = mem_rcolor;
        end
        cnt_next   = BOTTOM_ROW_START;
        state_next = ST_SCROLL_FILL;
      end

      ST_SCROLL_FILL: begin
        mem_we   = '{char_en: 1'b1, color_en: 1'b1};
        cnt_next = cnt + AW'(1);
        if (cnt == LAST_CELL) begin
          // a tab may still have spaces to write after the scroll
          state_next = (put_left != '0) ? ST_PUT : ST_DONE;
        end
      end

      ST_CLEAR: begin
        mem_we   = '{char_en: 1'b1, color_en: 1'b1};
        cnt_next = cnt + AW'(1);
        if (cnt == LAST_CELL) begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RESET_CLEAR;
      cnt      <= '0;
      cur_col  <= '0;
      cur_row  <= '0;
      cur_addr <= '0;
      put_left <= '0;
      scrolled <= 1'b0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      cur_col  <= cur_col_next;
      cur_row  <= cur_row_next;
      cur_addr <= cur_addr_next;
      put_left <= put_left_next;
      scrolled <= scrolled_next;
      pend     <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    put_ch    <= put_ch_next;
    tab_rem   <= tab_rem_next;
    res_char  <= res_char_next;
    res_color <= res_color_next;
    rd_addr   <= rd_addr_next;
    wdst      <= wdst_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color <= FILL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fill_color <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.cell_char    <= res_char;
      out_item.cell_color   <= res_color;
      out_item.cursor_col   <= 7'(cur_col);
      out_item.cursor_row   <= 5'(cur_row);
      out_item.cursor_index <= 11'(cur_addr);
      out_item.scrolled     <= scrolled;
    end
  end

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (rst)
    (cur_row <= LAST_ROW) && (cur_col <= LAST_COL))
    else $error("cursor left the grid");

  a_cursor_addr_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cur_addr == AW'(cur_row) * ROW_STEP + AW'(cur_col)))
    else $error("linear cursor address out of step with row and column");

  a_copy_write_in_scroll: assert property (@(posedge clk) disable iff (rst)
    pend |-> ((state == ST_SCROLL_COPY) || (state == ST_SCROLL_DRAIN)))
    else $error("scroll copy write pending outside scroll");

  a_scroll_on_bottom_row: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && scrolled) |-> (cur_row == LAST_ROW))
    else $error("scrolled result with cursor off the bottom row");

endmodule

FILE: tb/sv/tb_text_console_writer_unit.sv
module tb_text_console_writer_unit;
  import tcw_pkg::*;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_STOP  = 4;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_WAIT = 64;
  localparam int N_DIR     = 21;

  localparam logic [1:0] OP_NONE = 2'd3;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_PATTERN, STALL_HEAVY} stall_style_t;

  // one command with an optional hand-written result
  typedef struct packed {
    in_item_t  cmd;
    logic      known;
    out_item_t want;
  } console_cmd_t;

  // cmd: op, char, row, col | known | char, color, cursor col, cursor row, index, scrolled
  localparam console_cmd_t DIRECTED [N_DIR] = '{
    {OP_READ,  8'h00,      5'd0,  7'd0,   1'b1, 8'h00, FILL_RESET, 7'd0, 5'd0, 11'd0,  1'b0},
    {OP_READ,  8'hFF,      5'd24, 7'd79,  1'b1, 8'h00, FILL_RESET, 7'd0, 5'd0, 11'd0,  1'b0},
    {OP_READ,  8'h00,      5'd31, 7'd127, 1'b1, 8'h00, 8'h00,      7'd0, 5'd0, 11'd0,  1'b0},
    {OP_READ,  8'h00,      5'd25, 7'd0,   1'b1, 8'h00, 8'h00,      7'd0, 5'd0, 11'd0,  1'b0},
    {OP_READ,  8'h00,      5'd0,  7'd80,  1'b1, 8'h00, 8'h00,      7'd0, 5'd0, 11'd0,  1'b0},
    {OP_NONE,  8'hFF,      5'd31, 7'd127, 1'b1, 8'h00, 8'h00,      7'd0, 5'd0, 11'd0,  1'b0},
    {OP_PUT,   8'h41,      5'd31, 7'd127, 1'b1, 8'h00, 8'h00,      7'd1, 5'd0, 11'd1,  1'b0},
    {OP_PUT,   8'hFF,      5'd0,  7'd0,   1'b1, 8'h00, 8'h00,      7'd2, 5'd0, 11'd2,  1'b0},
    {OP_PUT,   CH_BLANK,   5'd0,  7'd0,   1'b1, 8'h00, 8'h00,      7'd3, 5'd0, 11'd3,  1'b0},
    {OP_PUT,   CH_TAB,     5'd0,  7'd0,   1'b1, 8'h00, 8'h00,      7'd4, 5'd0, 11'd4,  1'b0},
    {OP_PUT,   CH_TAB,     5'd0,  7'd0,   1'b1, 8'h00, 8'h00,      7'd8, 5'd0, 11'd8,  1'b0},
    {OP_READ,  8'h00,      5'd0,  7'd0,   1'b1, 8'h41, FILL_RESET, 7'd8, 5'd0, 11'd8,  1'b0},
    {OP_READ,  8'h00,      5'd0,  7'd1,   1'b1, 8'hFF, FILL_RESET, 7'd8, 5'd0, 11'd8,  1'b0},
    {OP_READ,  8'h00,      5'd0,  7'd3,   1'b1, CH_SPACE, FILL_RESET, 7'd8, 5'd0, 11'd8, 1'b0},
    {OP_PUT,   CH_RETURN,  5'd0,  7'd0,   1'b1, 8'h00, 8'h00,      7'd0, 5'd0, 11'd0,  1'b0},
    {OP_PUT,   CH_NEWLINE, 5'd0,  7'd0,   1'b1, 8'h00, 8'h00,      7'd0, 5'd1, 11'd80, 1'b0},
    {OP_PUT,   8'h7E,      5'd0,  7'd0,   1'b0, 40'd0},
    {OP_PUT,   CH_TAB,     5'd0,  7'd0,   1'b0, 40'd0},
    {OP_CLEAR, 8'hFF,      5'd31, 7'd127, 1'b1, 8'h00, 8'h00,      7'd0, 5'd0, 11'd0,  1'b0},
    {OP_READ,  8'h00,      5'd0,  7'd0,   1'b1, 8'h00, FILL_RESET, 7'd0, 5'd0, 11'd0,  1'b0},
    {OP_READ,  8'h00,      5'd1,  7'd0,   1'b0, 40'd0}
  };

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      cfg_valid = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_ready;

  // predicted console state
  logic [7:0] screen_chars  [CELLS];
  logic [7:0] screen_colors [CELLS];
  logic [7:0] fill_model;
  int         cur_col;
  int         cur_row;

  console_cmd_t commands_q[$];
  out_item_t    pending_results[$];
  int           fail_count  = 0;
  int           shown_count = 0;
  int           hold_asks   = 0;
  int           holds_done  = 0;

  text_console_writer_unit #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void blank_cells(int from);
    for (int i = from; i < CELLS; i++) begin
      screen_chars[i]  = CH_BLANK;
      screen_colors[i] = fill_model;
    end
  endfunction

  // wrap past the last column, scroll past the last row
  function automatic bit cursor_settle();
    bit moved_up = 1'b0;
    if (cur_col >= COLUMNS) begin
      cur_row++;
      cur_col = 0;
    end
    if (cur_row >= ROWS) begin
      for (int i = COLUMNS; i < CELLS; i++) begin
        screen_chars[i - COLUMNS]  = screen_chars[i];
        screen_colors[i - COLUMNS] = screen_colors[i];
      end
      blank_cells(CELLS - COLUMNS);
      cur_row  = ROWS - 1;
      moved_up = 1'b1;
    end
    return moved_up;
  endfunction

  function automatic bit put_plain(logic [7:0] ch);
    int idx;
    idx = cur_row * COLUMNS + cur_col;
    if (idx < CELLS) screen_chars[idx] = ch;
    cur_col++;
    return cursor_settle();
  endfunction

  function automatic out_item_t console_step(in_item_t cmd);
    out_item_t res;
    int        spaces;
    int        idx;
    res = '0;
    case (cmd.op)
      OP_PUT: begin
        if (cmd.char_code == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
          res.scrolled = cursor_settle();
        end else if (cmd.char_code == CH_RETURN) begin
          cur_col = 0;
          res.scrolled = cursor_settle();
        end else if (cmd.char_code == CH_TAB) begin
          // space count is fixed before the first space moves the cursor
          spaces = TAB_STOP - (cur_col % TAB_STOP);
          repeat (spaces) begin
            if (put_plain(CH_SPACE)) res.scrolled = 1'b1;
          end
        end else begin
          res.scrolled = put_plain(cmd.char_code);
        end
      end
      OP_CLEAR: begin
        blank_cells(0);
        cur_col = 0;
        cur_row = 0;
      end
      OP_READ: begin
        if (cmd.row < ROWS && cmd.col < COLUMNS) begin
          idx = cmd.row * COLUMNS + cmd.col;
          res.cell_char  = screen_chars[idx];
          res.cell_color = screen_colors[idx];
        end
      end
      default: ;
    endcase
    idx = cur_row * COLUMNS + cur_col;
    res.cursor_col   = cur_col[6:0];
    res.cursor_row   = cur_row[4:0];
    res.cursor_index = idx[10:0];
    return res;
  endfunction

  task automatic add_cmd(logic [1:0] op, logic [7:0] ch, logic [4:0] r, logic [6:0] c);
    console_cmd_t e;
    e = '0;
    e.cmd.op        = op;
    e.cmd.char_code = ch;
    e.cmd.row       = r;
    e.cmd.col       = c;
    commands_q.push_back(e);
  endtask

  task automatic add_put(logic [7:0] ch);
    add_cmd(OP_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endtask

  // mostly lines of text with their endings, plus reads, newline runs, tab runs, clears and noise
  task automatic plan_phase(int n);
    int kind;
    int len;
    while (commands_q.size() < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 40);
        repeat (len) begin
          case ($urandom_range(0, 19))
            0, 1:    add_put(CH_TAB);
            2:       add_put(8'($urandom_range(0, 255)));
            default: add_put(8'($urandom_range(8'h20, 8'h7E)));
          endcase
        end
        case ($urandom_range(0, 5))
          0: ;
          1: begin
            add_put(CH_RETURN);
            add_put(CH_NEWLINE);
          end
          2: add_put(CH_RETURN);
          default: add_put(CH_NEWLINE);
        endcase
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 7) == 0)
            add_cmd(OP_READ, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                    7'($urandom_range(0, 127)));
          else
            add_cmd(OP_READ, 8'($urandom_range(0, 255)), 5'($urandom_range(0, ROWS - 1)),
                    7'($urandom_range(0, COLUMNS - 1)));
        end
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 6)) add_put(CH_NEWLINE);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 8)) add_put(CH_TAB);
      end else if (kind < 88) begin
        add_cmd(OP_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                7'($urandom_range(0, 127)));
      end else if (kind < 95) begin
        repeat ($urandom_range(1, 5))
          add_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
      end else begin
        add_put(CH_RETURN);
        repeat ($urandom_range(0, 6)) add_put(8'($urandom_range(8'h20, 8'h7E)));
      end
    end
  endtask

  // send in bursts; predict each transaction as it is taken
  task automatic issue_commands();
    int burst;
    int gap;
    out_item_t predicted;
    while (commands_q.size() > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      while (burst > 0 && commands_q.size() > 0) begin
        in_valid <= 1'b1;
        in_item  <= commands_q[0].cmd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = console_step(commands_q[0].cmd);
        pending_results.push_back(commands_q[0].known ? commands_q[0].want : predicted);
        commands_q.delete(0);
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic write_fill(logic [7:0] value);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fill_model = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    stall_style_t style;
    int span;
    int tick;
    tick = 0;
    forever begin
      style = stall_style_t'($urandom_range(0, 3));
      span  = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_asks != holds_done) begin
          // long hold so the block backs up and stalls its input
          holds_done++;
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
        end else begin
          case (style)
            STALL_NONE:    out_stall <= 1'b0;
            STALL_COIN:    out_stall <= ($urandom_range(0, 1) == 0);
            STALL_PATTERN: out_stall <= (tick % 5 < 2);
            default:       out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (shown_count < 10) begin
          shown_count++;
          $display("unexpected result at %0t: char %h color %h col %0d row %0d index %0d",
                   $realtime, out_item.cell_char, out_item.cell_color, out_item.cursor_col,
                   out_item.cursor_row, out_item.cursor_index);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_item.cell_char !== want.cell_char || out_item.cell_color !== want.cell_color ||
            out_item.cursor_col !== want.cursor_col || out_item.cursor_row !== want.cursor_row ||
            out_item.cursor_index !== want.cursor_index || out_item.scrolled !== want.scrolled)
        begin
          fail_count++;
          if (shown_count < 10) begin
            shown_count++;
            $display("mismatch at %0t: expected char %h color %h col %0d row %0d index %0d scr %b",
                     $realtime, want.cell_char, want.cell_color, want.cursor_col,
                     want.cursor_row, want.cursor_index, want.scrolled);
            $display("                 got char %h color %h col %0d row %0d index %0d scr %b",
                     out_item.cell_char, out_item.cell_color, out_item.cursor_col,
                     out_item.cursor_row, out_item.cursor_index, out_item.scrolled);
          end
        end
      end
    end
  end

  initial begin : main_seq
    logic [7:0] fills [5];
    fill_model = FILL_RESET;
    blank_cells(0);
    cur_col  = 0;
    cur_row  = 0;
    fills[0] = 8'h00;
    fills[1] = 8'hFF;
    fills[2] = 8'($urandom_range(0, 255));
    fills[3] = 8'h80;
    fills[4] = 8'($urandom_range(0, 255));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) commands_q.push_back(DIRECTED[i]);
    issue_commands();

    for (int ph = 0; ph < 5; ph++) begin
      write_fill(fills[ph]);
      if (ph % 2 == 1) hold_asks++;
      plan_phase(150);
      issue_commands();
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;

    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #(100_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_cell_ram.sv
rtl/core/text_console_writer_unit.sv
tb/sv/tb_text_console_writer_unit.sv
